// ----- rtl/abp_pkg.sv -----
// Shared widths, angle constants and the arctangent table of the angle bisector point unit.
package abp_pkg;

  // Default and largest number of CORDIC iterations
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned MAX_STEPS    = 32;

  // Coordinate and difference widths (8 fraction bits)
  localparam int unsigned COORD_W = 24;
  localparam int unsigned DIFF_W  = COORD_W + 1;

  // Vectoring datapath: arm vectors scaled by 2^16, room for CORDIC growth
  localparam int unsigned VEC_SHIFT = 16;
  localparam int unsigned VEC_W     = 44;

  // Binary angles: 2^32 is a full turn
  localparam int unsigned          ANG_W       = 32;
  localparam logic [ANG_W-1:0]     ANG_HALF    = 32'h8000_0000;
  localparam logic [ANG_W-1:0]     ANG_QUARTER = 32'h4000_0000;

  // Gain compensation 0x26DD3B6A / 2^30 applied to the distance
  localparam int unsigned          GAIN_W   = 31;
  localparam logic signed [GAIN_W-1:0] GAIN_INV = 31'sd652032874;
  localparam int unsigned          PROD_W   = COORD_W + GAIN_W;
  localparam int unsigned          XR_SHIFT = 14;
  localparam int unsigned          XR_W     = PROD_W - XR_SHIFT;

  // Rotation datapath: 24 fraction bits, signed angle residue
  localparam int unsigned ROT_W       = 50;
  localparam int unsigned ZR_W        = ANG_W + 2;
  localparam int unsigned ROUND_SHIFT = 16;

  // Sideband that travels with each transaction through the pipeline
  typedef struct packed {
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic                      degen;
    logic                      zero2;
  } side_t;

  // arctan(2^-i) as a binary angle
  function automatic logic [ANG_W-1:0] atan_angle(input int unsigned idx);
    logic [ANG_W-1:0] a;
    case (idx)
      0:  a = 32'h2000_0000;
      1:  a = 32'h12E4_051E;
      2:  a = 32'h09FB_385B;
      3:  a = 32'h0511_11D4;
      4:  a = 32'h028B_0D43;
      5:  a = 32'h0145_D7E1;
      6:  a = 32'h00A2_F61E;
      7:  a = 32'h0051_7C55;
      8:  a = 32'h0028_BE53;
      9:  a = 32'h0014_5F2F;
      10: a = 32'h000A_2F98;
      11: a = 32'h0005_17CC;
      12: a = 32'h0002_8BE6;
      13: a = 32'h0001_45F3;
      14: a = 32'h0000_A2FA;
      15: a = 32'h0000_517D;
      16: a = 32'h0000_28BE;
      17: a = 32'h0000_145F;
      18: a = 32'h0000_0A30;
      19: a = 32'h0000_0518;
      20: a = 32'h0000_028C;
      21: a = 32'h0000_0146;
      22: a = 32'h0000_00A3;
      23: a = 32'h0000_0051;
      24: a = 32'h0000_0029;
      25: a = 32'h0000_0014;
      26: a = 32'h0000_000A;
      27: a = 32'h0000_0005;
      28: a = 32'h0000_0003;
      29: a = 32'h0000_0001;
      30: a = 32'h0000_0001;
      default: a = 32'h0000_0000;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/abp_req_if.sv -----
// Request channel: three points and a distance with valid/ready handshake.
interface abp_req_if;
  logic                                valid;
  logic                                ready;
  logic signed [abp_pkg::COORD_W-1:0] first_x;
  logic signed [abp_pkg::COORD_W-1:0] first_y;
  logic signed [abp_pkg::COORD_W-1:0] vertex_x;
  logic signed [abp_pkg::COORD_W-1:0] vertex_y;
  logic signed [abp_pkg::COORD_W-1:0] third_x;
  logic signed [abp_pkg::COORD_W-1:0] third_y;
  logic signed [abp_pkg::COORD_W-1:0] distance;

  modport source (
    output valid, first_x, first_y, vertex_x, vertex_y, third_x, third_y, distance,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, vertex_x, vertex_y, third_x, third_y, distance,
    output ready
  );
endinterface

// ----- rtl/abp_rsp_if.sv -----
// Response channel: bisector point and degenerate flag with valid/ready handshake.
interface abp_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [abp_pkg::COORD_W-1:0] result_x;
  logic signed [abp_pkg::COORD_W-1:0] result_y;
  logic                                degenerate;

  modport source (
    output valid, result_x, result_y, degenerate,
    input  ready
  );
  modport sink (
    input  valid, result_x, result_y, degenerate,
    output ready
  );
endinterface

// ----- rtl/abp_vectoring.sv -----
// Pipelined CORDIC in vectoring mode: one iteration per register stage, yields the angle.
module abp_vectoring #(
  parameter int unsigned STEPS = abp_pkg::CORDIC_STEPS
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [abp_pkg::VEC_W-1:0] x_i,
  input  logic signed [abp_pkg::VEC_W-1:0] y_i,
  input  logic        [abp_pkg::ANG_W-1:0] z_i,
  output logic        [abp_pkg::ANG_W-1:0] z_o
);

  localparam int unsigned VW = abp_pkg::VEC_W;
  localparam int unsigned AW = abp_pkg::ANG_W;

  // x feeds y of the next stage, y feeds the last direction decision
  logic signed [VW-1:0] x_q [STEPS-2];
  logic signed [VW-1:0] y_q [STEPS-1];
  logic        [AW-1:0] z_q [STEPS];

  for (genvar g = 0; g < STEPS; g++) begin : g_stage
    logic signed [VW-1:0] yi;
    logic        [AW-1:0] zi;
    logic                 go_up;

    if (g == 0) begin : g_src
      assign yi = y_i;
      assign zi = z_i;
    end else begin : g_src
      assign yi = y_q[g-1];
      assign zi = z_q[g-1];
    end

    // Rotate toward the x axis: positive y turns clockwise
    assign go_up = !yi[VW-1] && (yi != '0);

    // Accumulate angle
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[g] <= go_up ? zi + abp_pkg::atan_angle(g) : zi - abp_pkg::atan_angle(g);
      end
    end

    if (g < STEPS - 1) begin : g_y
      logic signed [VW-1:0] xi;

      if (g == 0) begin : g_xsrc
        assign xi = x_i;
      end else begin : g_xsrc
        assign xi = x_q[g-1];
      end

      // Advance y
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          y_q[g] <= go_up ? yi - (xi >>> g) : yi + (xi >>> g);
        end
      end

      if (g < STEPS - 2) begin : g_x
        // Advance x
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            x_q[g] <= go_up ? xi + (yi >>> g) : xi - (yi >>> g);
          end
        end
      end
    end
  end

  assign z_o = z_q[STEPS-1];

endmodule

// ----- rtl/abp_rotation.sv -----
// Pipelined CORDIC in rotation mode: one iteration per register stage, yields (x, y).
module abp_rotation #(
  parameter int unsigned STEPS = abp_pkg::CORDIC_STEPS
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [abp_pkg::ROT_W-1:0] x_i,
  input  logic signed [abp_pkg::ZR_W-1:0]  z_i,
  output logic signed [abp_pkg::ROT_W-1:0] x_o,
  output logic signed [abp_pkg::ROT_W-1:0] y_o
);

  localparam int unsigned RW = abp_pkg::ROT_W;
  localparam int unsigned ZW = abp_pkg::ZR_W;

  logic signed [RW-1:0] x_q [STEPS];
  logic signed [RW-1:0] y_q [STEPS];
  logic signed [ZW-1:0] z_q [STEPS-1];

  for (genvar g = 0; g < STEPS; g++) begin : g_stage
    logic signed [RW-1:0] xi;
    logic signed [RW-1:0] yi;
    logic signed [ZW-1:0] zi;
    logic signed [ZW-1:0] at_s;
    logic                 go_ccw;

    if (g == 0) begin : g_src
      assign xi = x_i;
      assign yi = '0;
      assign zi = z_i;
    end else begin : g_src
      assign xi = x_q[g-1];
      assign yi = y_q[g-1];
      assign zi = z_q[g-1];
    end

    assign at_s   = signed'(ZW'(abp_pkg::atan_angle(g)));
    assign go_ccw = !zi[ZW-1];

    // Rotate the vector by the residual angle sign
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[g] <= go_ccw ? xi - (yi >>> g) : xi + (yi >>> g);
        y_q[g] <= go_ccw ? yi + (xi >>> g) : yi - (xi >>> g);
      end
    end

    if (g < STEPS - 1) begin : g_z
      // Reduce residual angle
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          z_q[g] <= go_ccw ? zi - at_s : zi + at_s;
        end
      end
    end
  end

  assign x_o = x_q[STEPS-1];
  assign y_o = y_q[STEPS-1];

endmodule

// ----- rtl/angle_bisector_point_unit.sv -----
// Angle bisector point unit: point at a signed distance along the interior angle bisector.
//
// Usage:
//   req_i carries one transaction per point triple: first arm end, vertex, second arm end
//   and a signed distance, all 24-bit signed with 8 fraction bits. rsp_o returns one
//   transaction per request, in order: the bisector point (saturated to 24 bits) and a
//   degenerate flag, set when the first arm has zero length and the vertex is returned.
//   Throughput: one transaction per cycle while the skid register is empty (see Stall);
//   every CORDIC iteration of both the vectoring and the rotation pass is its own pipeline
//   stage, as are operand setup, angle combine and the final round and saturate.
//   The two arm angles are found by two vectoring pipelines side by side, the point by one
//   rotation pipeline fed with the gain-compensated distance.
//   Stall: when rsp_o.ready is low the result holds in the output register; the pipeline
//   keeps moving until one more finished result sits in a skid register, and only then
//   drops req_i.ready. Nothing is lost or repeated.
//   Reset: rst_ni clears all valid bits; the pipeline comes up empty and ready.
module angle_bisector_point_unit #(
  parameter int unsigned CORDIC_STEPS = abp_pkg::CORDIC_STEPS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  abp_req_if.sink   req_i,
  abp_rsp_if.source rsp_o
);

  localparam int unsigned CW     = abp_pkg::COORD_W;
  localparam int unsigned DW     = abp_pkg::DIFF_W;
  localparam int unsigned VW     = abp_pkg::VEC_W;
  localparam int unsigned AW     = abp_pkg::ANG_W;
  localparam int unsigned XW     = abp_pkg::XR_W;
  localparam int unsigned PW     = abp_pkg::PROD_W;
  localparam int unsigned RW     = abp_pkg::ROT_W;
  localparam int unsigned ZW     = abp_pkg::ZR_W;
  localparam int unsigned RND_W  = RW + 1;
  localparam int unsigned SH_W   = RND_W - abp_pkg::ROUND_SHIFT;
  localparam int unsigned SUM_W  = SH_W + 1;
  // setup, vectoring, combine, rotation and final stages
  localparam int unsigned NS     = 2 * CORDIC_STEPS + 4;

  localparam logic signed [ZW-1:0]    Z_QUARTER = ZW'(abp_pkg::ANG_QUARTER);
  localparam logic signed [ZW-1:0]    Z_HALF    = ZW'(abp_pkg::ANG_HALF);
  localparam logic signed [RND_W-1:0] RND_HALF  =
    RND_W'(2 ** (abp_pkg::ROUND_SHIFT - 1));
  localparam logic signed [SUM_W-1:0] OUT_MAX   = SUM_W'(2 ** (CW - 1) - 1);
  localparam logic signed [SUM_W-1:0] OUT_MIN   = -OUT_MAX - SUM_W'(1);

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic        [AW-1:0] z;
  } vec_t;

  // Scale an arm to the vectoring format, flip y for screen convention, fold into right half
  function automatic vec_t arm_setup(input logic signed [DW-1:0] dx,
                                     input logic signed [DW-1:0] dy);
    vec_t                 v;
    logic signed [VW-1:0] sx;
    logic signed [VW-1:0] sy;
    sx = VW'(dx) <<< abp_pkg::VEC_SHIFT;
    sy = VW'(dy) <<< abp_pkg::VEC_SHIFT;
    if (sx[VW-1]) begin
      v.x = -sx;
      v.y = sy;
      v.z = abp_pkg::ANG_HALF;
    end else begin
      v.x = sx;
      v.y = -sy;
      v.z = '0;
    end
    return v;
  endfunction

  function automatic logic signed [CW-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic signed [CW-1:0] r;
    if (v > OUT_MAX) begin
      r = OUT_MAX[CW-1:0];
    end else if (v < OUT_MIN) begin
      r = OUT_MIN[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [XW-1:0] p_shift(input logic signed [PW-1:0] p);
    return p[PW-1:abp_pkg::XR_SHIFT];
  endfunction

  logic en;
  logic [NS-1:0] v_q;
  logic out_v_q;
  logic skid_v_q;

  // Advance the whole pipeline unless the skid register is occupied
  assign en          = !skid_v_q;
  assign req_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-2:0], req_i.valid};
    end
  end

  // Stage P0: arm differences
  logic signed [CW-1:0] p0_vx_q, p0_vy_q, p0_dist_q;
  logic signed [DW-1:0] p0_dx1_q, p0_dy1_q, p0_dx2_q, p0_dy2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_vx_q   <= req_i.vertex_x;
      p0_vy_q   <= req_i.vertex_y;
      p0_dist_q <= req_i.distance;
      p0_dx1_q  <= DW'(req_i.first_x) - DW'(req_i.vertex_x);
      p0_dy1_q  <= DW'(req_i.first_y) - DW'(req_i.vertex_y);
      p0_dx2_q  <= DW'(req_i.third_x) - DW'(req_i.vertex_x);
      p0_dy2_q  <= DW'(req_i.third_y) - DW'(req_i.vertex_y);
    end
  end

  // Stage P1: vectoring setup, zero-arm flags, gain-compensated distance
  vec_t                  p1_a1_q, p1_a2_q;
  abp_pkg::side_t        p1_side_q;
  logic signed [XW-1:0]  p1_xr_q;
  logic signed [PW-1:0]  dist_prod;

  assign dist_prod = PW'(p0_dist_q) * PW'(abp_pkg::GAIN_INV);

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_a1_q         <= arm_setup(p0_dx1_q, p0_dy1_q);
      p1_a2_q         <= arm_setup(p0_dx2_q, p0_dy2_q);
      p1_side_q.vx    <= p0_vx_q;
      p1_side_q.vy    <= p0_vy_q;
      p1_side_q.degen <= (p0_dx1_q == '0) && (p0_dy1_q == '0);
      p1_side_q.zero2 <= (p0_dx2_q == '0) && (p0_dy2_q == '0);
      p1_xr_q         <= p_shift(dist_prod);
    end
  end

  // Vectoring stages: both arm angles side by side
  logic [AW-1:0] ang1, ang2;

  abp_vectoring #(
    .STEPS (CORDIC_STEPS)
  ) u_vec_first (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (p1_a1_q.x),
    .y_i   (p1_a1_q.y),
    .z_i   (p1_a1_q.z),
    .z_o   (ang1)
  );

  abp_vectoring #(
    .STEPS (CORDIC_STEPS)
  ) u_vec_third (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (p1_a2_q.x),
    .y_i   (p1_a2_q.y),
    .z_i   (p1_a2_q.z),
    .z_o   (ang2)
  );

  // Carry sideband alongside the vectoring stages
  abp_pkg::side_t       sv_q [CORDIC_STEPS];
  logic signed [XW-1:0] xv_q [CORDIC_STEPS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sv_q[0] <= p1_side_q;
      xv_q[0] <= p1_xr_q;
      for (int i = 1; i < CORDIC_STEPS; i++) begin
        sv_q[i] <= sv_q[i-1];
        xv_q[i] <= xv_q[i-1];
      end
    end
  end

  // Stage A: bisector angle, fold into the rotation range
  abp_pkg::side_t       sv_last;
  logic [AW-1:0]        a2_eff, diff, bis;
  logic signed [ZW-1:0] zb, za_d;
  logic signed [RW-1:0] xb, xa_d;
  abp_pkg::side_t       a_side_q;
  logic signed [RW-1:0] a_x_q;
  logic signed [ZW-1:0] a_z_q;

  assign sv_last = sv_q[CORDIC_STEPS-1];

  always_comb begin
    a2_eff = sv_last.zero2 ? '0 : ang2;
    diff   = a2_eff - ang1;
    if (diff > abp_pkg::ANG_HALF) begin
      bis = ang1 - ((~diff + AW'(1)) >> 1);
    end else begin
      bis = ang1 + (diff >> 1);
    end
    zb = ZW'(signed'(bis));
    xb = RW'(xv_q[CORDIC_STEPS-1]);
    if (zb > Z_QUARTER) begin
      xa_d = -xb;
      za_d = zb - Z_HALF;
    end else if (zb < -Z_QUARTER) begin
      xa_d = -xb;
      za_d = zb + Z_HALF;
    end else begin
      xa_d = xb;
      za_d = zb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_side_q <= sv_last;
      a_x_q    <= xa_d;
      a_z_q    <= za_d;
    end
  end

  // Rotation stages
  logic signed [RW-1:0] rot_x, rot_y;

  abp_rotation #(
    .STEPS (CORDIC_STEPS)
  ) u_rot (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (a_x_q),
    .z_i   (a_z_q),
    .x_o   (rot_x),
    .y_o   (rot_y)
  );

  abp_pkg::side_t sr_q [CORDIC_STEPS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sr_q[0] <= a_side_q;
      for (int i = 1; i < CORDIC_STEPS; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  // Stage F: round, offset from vertex (y flips back to screen), saturate; a degenerate request passes the vertex
  abp_pkg::side_t        sr_last;
  logic signed [RND_W-1:0] rnd_x, rnd_y;
  logic signed [SH_W-1:0]  sh_x, sh_y;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic signed [CW-1:0]    f_x_q, f_y_q;
  logic                    f_deg_q;

  assign sr_last = sr_q[CORDIC_STEPS-1];
  assign rnd_x   = RND_W'(rot_x) + RND_HALF;
  assign rnd_y   = RND_W'(rot_y) + RND_HALF;
  assign sh_x    = rnd_x[RND_W-1:abp_pkg::ROUND_SHIFT];
  assign sh_y    = rnd_y[RND_W-1:abp_pkg::ROUND_SHIFT];
  assign sum_x   = SUM_W'(sr_last.vx) + SUM_W'(sh_x);
  assign sum_y   = SUM_W'(sr_last.vy) - SUM_W'(sh_y);

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_deg_q <= sr_last.degen;
      if (sr_last.degen) begin
        f_x_q <= sr_last.vx;
        f_y_q <= sr_last.vy;
      end else begin
        f_x_q <= sat(sum_x);
        f_y_q <= sat(sum_y);
      end
    end
  end

  // Output register with one skid entry
  logic tail_push, out_fire;
  logic out_v_d, skid_v_d;
  logic load_out_skid, load_out_tail, load_skid;
  logic signed [CW-1:0] out_x_q, out_y_q, skid_x_q, skid_y_q;
  logic                 out_deg_q, skid_deg_q;

  assign tail_push = v_q[NS-1] && en;
  assign out_fire  = out_v_q && rsp_o.ready;

  always_comb begin
    out_v_d       = out_v_q;
    skid_v_d      = skid_v_q;
    load_out_skid = 1'b0;
    load_out_tail = 1'b0;
    load_skid     = 1'b0;
    if (skid_v_q) begin
      if (out_fire) begin
        load_out_skid = 1'b1;
        skid_v_d      = 1'b0;
      end
    end else if (!out_v_q || out_fire) begin
      out_v_d       = tail_push;
      load_out_tail = tail_push;
    end else if (tail_push) begin
      skid_v_d  = 1'b1;
      load_skid = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out_skid) begin
      out_x_q   <= skid_x_q;
      out_y_q   <= skid_y_q;
      out_deg_q <= skid_deg_q;
    end else if (load_out_tail) begin
      out_x_q   <= f_x_q;
      out_y_q   <= f_y_q;
      out_deg_q <= f_deg_q;
    end
    if (load_skid) begin
      skid_x_q   <= f_x_q;
      skid_y_q   <= f_y_q;
      skid_deg_q <= f_deg_q;
    end
  end

  assign rsp_o.valid      = out_v_q;
  assign rsp_o.result_x   = out_x_q;
  assign rsp_o.result_y   = out_y_q;
  assign rsp_o.degenerate = out_deg_q;

  // The skid entry is only ever filled behind a waiting output transaction
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds a result while the output register is empty");

  // A finished result that meets a stalled output lands in the skid register
  a_tail_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NS-1] && en && out_v_q && !rsp_o.ready) |=> skid_v_q)
    else $error("pipeline tail result dropped under output stall");

  // A waiting output transaction stays valid until taken
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !rsp_o.ready) |=> out_v_q)
    else $error("output transaction withdrawn before it was taken");

  // Taking the output drains the skid entry into the output register
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && rsp_o.ready) |=> (!skid_v_q && out_v_q))
    else $error("skid entry not moved to the output register");

endmodule

// ----- sim/angle_bisector_point_unit_checker.sv -----
// Checker for the angle bisector point unit: predicts each bisector point and compares results.
module angle_bisector_point_unit_checker #(
  parameter int unsigned STEPS = abp_pkg::CORDIC_STEPS
) (
  input  logic clk_i,
  input  logic rst_ni,
  abp_req_if   req_mon,
  abp_rsp_if   rsp_mon,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_ITER = (STEPS > abp_pkg::MAX_STEPS) ? abp_pkg::MAX_STEPS : STEPS;

  // Gain compensation of the rotation pass, 2^-30 units
  localparam longint GAIN_COMP = 64'sd652032874;

  localparam longint OUT_LO = -64'sd8388608;
  localparam longint OUT_HI = 64'sd8388607;

  // arctan(2^-i), full turn = 2^32
  localparam logic [abp_pkg::ANG_W-1:0] ARCTAN_STEP [32] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
    32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
    32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
  };

  typedef struct {
    logic signed [abp_pkg::COORD_W-1:0] x;
    logic signed [abp_pkg::COORD_W-1:0] y;
    logic                               degen;
  } bisector_point_t;

  bisector_point_t expected_points[$];

  // Screen-convention direction of an arm, atan2(-dy, dx) as a binary angle
  function automatic logic [abp_pkg::ANG_W-1:0] arm_angle(input longint dx, input longint dy);
    longint                    ax;
    longint                    ay;
    longint                    nx;
    logic [abp_pkg::ANG_W-1:0] acc;
    int                        i;
    acc = '0;
    if (dx == 0 && dy == 0) begin
      return acc;
    end
    ax = dx * 65536;
    ay = -dy * 65536;
    // Fold the left half plane onto the right one
    if (ax < 0) begin
      ax  = -ax;
      ay  = -ay;
      acc = abp_pkg::ANG_HALF;
    end
    for (i = 0; i < N_ITER; i++) begin
      if (ay > 0) begin
        nx  = ax + (ay >>> i);
        ay  = ay - (ax >>> i);
        acc = acc + ARCTAN_STEP[i];
      end else begin
        nx  = ax - (ay >>> i);
        ay  = ay + (ax >>> i);
        acc = acc - ARCTAN_STEP[i];
      end
      ax = nx;
    end
    return acc;
  endfunction

  function automatic longint clamp_coord(input longint v);
    if (v < OUT_LO) return OUT_LO;
    if (v > OUT_HI) return OUT_HI;
    return v;
  endfunction

  // Point at the given distance along the interior bisector of the angle
  function automatic bisector_point_t bisector_point(
    input longint fx, input longint fy, input longint vx, input longint vy,
    input longint tx, input longint ty, input longint reach
  );
    bisector_point_t           p;
    logic [abp_pkg::ANG_W-1:0] a1;
    logic [abp_pkg::ANG_W-1:0] a2;
    logic [abp_pkg::ANG_W-1:0] turn;
    logic [abp_pkg::ANG_W-1:0] bis;
    longint                    rx;
    longint                    ry;
    longint                    nx;
    longint                    rz;
    longint                    quarter;
    longint                    half;
    int                        i;
    quarter = abp_pkg::ANG_QUARTER;
    half    = abp_pkg::ANG_HALF;
    // Zero first arm: return the vertex and flag it
    if (fx == vx && fy == vy) begin
      p.x     = vx[abp_pkg::COORD_W-1:0];
      p.y     = vy[abp_pkg::COORD_W-1:0];
      p.degen = 1'b1;
      return p;
    end
    a1   = arm_angle(fx - vx, fy - vy);
    a2   = arm_angle(tx - vx, ty - vy);
    turn = a2 - a1;
    // Reflex turn rotates back by half the complement, else forward by half the turn
    if (turn > abp_pkg::ANG_HALF) begin
      bis = a1 - ((32'd0 - turn) >> 1);
    end else begin
      bis = a1 + (turn >> 1);
    end
    rx = (reach * GAIN_COMP) >>> abp_pkg::XR_SHIFT;
    ry = 0;
    rz = bis;
    if (bis[abp_pkg::ANG_W-1]) begin
      rz = rz - 64'sd4294967296;
    end
    // Bring the angle into -90..+90 degrees
    if (rz > quarter) begin
      rx = -rx;
      rz = rz - half;
    end else if (rz < -quarter) begin
      rx = -rx;
      rz = rz + half;
    end
    for (i = 0; i < N_ITER; i++) begin
      if (rz >= 0) begin
        nx = rx - (ry >>> i);
        ry = ry + (rx >>> i);
        rz = rz - longint'(ARCTAN_STEP[i]);
      end else begin
        nx = rx + (ry >>> i);
        ry = ry - (rx >>> i);
        rz = rz + longint'(ARCTAN_STEP[i]);
      end
      rx = nx;
    end
    // Round to 8 fraction bits, y grows downward
    rx      = clamp_coord(vx + ((rx + 32768) >>> abp_pkg::ROUND_SHIFT));
    ry      = clamp_coord(vy - ((ry + 32768) >>> abp_pkg::ROUND_SHIFT));
    p.x     = rx[abp_pkg::COORD_W-1:0];
    p.y     = ry[abp_pkg::COORD_W-1:0];
    p.degen = 1'b0;
    return p;
  endfunction

  // Check each result transaction against the oldest prediction, then record new requests
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    bisector_point_t oldest;
    if (!rst_ni) begin
      expected_points.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d degenerate=%0b", $time,
                   rsp_mon.result_x, rsp_mon.result_y, rsp_mon.degenerate);
          fail_count_o++;
        end else begin
          oldest = expected_points.pop_front();
          if (rsp_mon.result_x !== oldest.x || rsp_mon.result_y !== oldest.y ||
              rsp_mon.degenerate !== oldest.degen) begin
            $display("%0t: mismatch expected x=%0d y=%0d degenerate=%0b,",
                     $time, oldest.x, oldest.y, oldest.degen,
                     " actual x=%0d y=%0d degenerate=%0b",
                     rsp_mon.result_x, rsp_mon.result_y, rsp_mon.degenerate);
            fail_count_o++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        expected_points.push_back(bisector_point(
          req_mon.first_x, req_mon.first_y, req_mon.vertex_x, req_mon.vertex_y,
          req_mon.third_x, req_mon.third_y, req_mon.distance));
      end
      pending_o = expected_points.size();
    end
  end

endmodule

// ----- sim/angle_bisector_point_unit_tb.sv -----
// Testbench top of the angle bisector point unit: clock, reset, stimulus and verdict.
module angle_bisector_point_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STEPS        = abp_pkg::CORDIC_STEPS;
  localparam int          LATENCY      = 2 * STEPS + 4;
  localparam int          RANDOM_ITEMS = 1500;
  localparam int          QUIET_ITEMS  = 200;
  localparam int          PAUSE_AT     = 900;
  localparam int          HOLD_AT      = 400;
  localparam int          HOLD_CYCLES  = 200;
  localparam int          COORD_MIN    = -8388608;
  localparam int          COORD_MAX    = 8388607;
  localparam int          PX           = 256;

  typedef logic signed [abp_pkg::COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t fx;
    coord_t fy;
    coord_t vx;
    coord_t vy;
    coord_t tx;
    coord_t ty;
    coord_t reach;
  } point_req_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   items_sent;
  bit   quiet_tail;

  abp_req_if req_if ();
  abp_rsp_if rsp_if ();

  angle_bisector_point_unit #(
    .CORDIC_STEPS(STEPS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  angle_bisector_point_unit_checker #(
    .STEPS(STEPS)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_mon     (req_if),
    .rsp_mon     (rsp_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic coord_t rand_coord();
    logic [31:0] r;
    r = $urandom;
    return r[abp_pkg::COORD_W-1:0];
  endfunction

  function automatic coord_t offset_coord(input coord_t base, input int off);
    int s;
    s = base + off;
    return coord_t'(s);
  endfunction

  function automatic coord_t near_coord(input coord_t base, input int span);
    return offset_coord(base, int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic point_req_t point_req(input int fx, input int fy, input int vx,
                                           input int vy, input int tx, input int ty,
                                           input int reach);
    point_req_t r;
    r.fx    = coord_t'(fx);
    r.fy    = coord_t'(fy);
    r.vx    = coord_t'(vx);
    r.vy    = coord_t'(vy);
    r.tx    = coord_t'(tx);
    r.ty    = coord_t'(ty);
    r.reach = coord_t'(reach);
    return r;
  endfunction

  // Offer one transaction and hold it until accepted
  task automatic offer_point(input point_req_t r);
    req_if.valid    <= 1'b1;
    req_if.first_x  <= r.fx;
    req_if.first_y  <= r.fy;
    req_if.vertex_x <= r.vx;
    req_if.vertex_y <= r.vy;
    req_if.third_x  <= r.tx;
    req_if.third_y  <= r.ty;
    req_if.distance <= r.reach;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Insert a random idle burst now and then, none in the quiet tail
  task automatic send_point(input point_req_t r);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    offer_point(r);
  endtask

  // Result side: random stall bursts, one long hold-off to fill the pipeline
  initial begin : receiver
    int  burst;
    bit  hold_done;
    rsp_if.ready = 1'b0;
    hold_done    = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        rsp_if.ready <= 1'b0;
        burst = HOLD_CYCLES;
      end else if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        rsp_if.ready <= 1'b0;
        burst = $urandom_range(1, 18);
      end else begin
        rsp_if.ready <= 1'b1;
        burst = $urandom_range(1, 40);
      end
      repeat (burst - 1) @(negedge clk_i);
    end
  end

  initial begin : stimulus
    point_req_t r;
    int         pick;
    int         n;
    int         span;
    int         ox;
    int         oy;
    int         m;
    items_sent      = 0;
    quiet_tail      = 1'b0;
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.first_x  = '0;
    req_if.first_y  = '0;
    req_if.vertex_x = '0;
    req_if.vertex_y = '0;
    req_if.third_x  = '0;
    req_if.third_y  = '0;
    req_if.distance = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Zero first arm, also at the field extremes
    send_point(point_req(100*PX, 50*PX, 100*PX, 50*PX, 300*PX, 10*PX, 40*PX));
    send_point(point_req(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                         COORD_MAX));
    send_point(point_req(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                         COORD_MAX));
    // Zero second arm
    send_point(point_req(150*PX, 50*PX, 100*PX, 50*PX, 100*PX, 50*PX, 30*PX));
    // Turn of zero, straight angle both ways, reflex and right turns
    send_point(point_req(110*PX, 0, 100*PX, 0, 130*PX, 0, 20*PX));
    send_point(point_req(110*PX, 0, 100*PX, 0, 90*PX, 0, 20*PX));
    send_point(point_req(90*PX, 0, 100*PX, 0, 110*PX, 0, -20*PX));
    send_point(point_req(0, -5*PX, 0, 0, 0, 5*PX, 100*PX));
    send_point(point_req(5*PX, 5*PX, 0, 0, -5*PX, -5*PX, 60*PX));
    send_point(point_req(110*PX, 0, 100*PX, 0, 100*PX, 10*PX, 25*PX));
    send_point(point_req(110*PX, 0, 100*PX, 0, 100*PX, -10*PX, 25*PX));
    send_point(point_req(-7*PX, 3*PX, 0, 0, -2*PX, -9*PX, -77*PX));
    // Zero distance
    send_point(point_req(3*PX, 7*PX, -5*PX, 2*PX, 9*PX, -4*PX, 0));
    // Saturation toward both ends
    send_point(point_req(COORD_MAX, 0, 8388000, 0, COORD_MAX, -1000, COORD_MAX));
    send_point(point_req(COORD_MIN, 0, -8388000, 0, COORD_MIN, 1000, COORD_MAX));
    send_point(point_req(0, COORD_MAX, 0, COORD_MAX - 600, 500, COORD_MAX, COORD_MIN));
    // Longest arms and one-LSB arms
    send_point(point_req(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX,
                         COORD_MIN));
    send_point(point_req(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN,
                         COORD_MAX));
    send_point(point_req(-1, -1, 0, 0, -1, -1, -1));
    send_point(point_req(1, 0, 0, 0, 0, 1, COORD_MAX));

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // Drain the pipeline completely once, mid run
      if (n == PAUSE_AT) begin
        req_if.valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk_i);
      end
      quiet_tail = (n >= RANDOM_ITEMS - QUIET_ITEMS);
      r.fx    = rand_coord();
      r.fy    = rand_coord();
      r.vx    = rand_coord();
      r.vy    = rand_coord();
      r.tx    = rand_coord();
      r.ty    = rand_coord();
      r.reach = rand_coord();
      span    = 1 << $urandom_range(1, 16);
      pick    = $urandom_range(0, 99);
      if (pick < 25) begin
        // keep the fully random fields
      end else if (pick < 55) begin
        // Small angle around a random vertex
        r.fx    = near_coord(r.vx, span);
        r.fy    = near_coord(r.vy, span);
        r.tx    = near_coord(r.vx, span);
        r.ty    = near_coord(r.vy, span);
        r.reach = near_coord(coord_t'(0), 1 << $urandom_range(4, 20));
      end else if (pick < 65) begin
        r.fx = r.vx;
        r.fy = r.vy;
      end else if (pick < 75) begin
        r.fx = near_coord(r.vx, span);
        r.fy = near_coord(r.vy, span);
        r.tx = r.vx;
        r.ty = r.vy;
      end else if (pick < 85) begin
        // Collinear arms: turn of zero or a straight angle
        ox   = int'($urandom_range(0, 2 * span)) - span;
        oy   = int'($urandom_range(0, 2 * span)) - span;
        m    = $urandom_range(1, 4);
        if ($urandom_range(0, 1) == 0) m = -m;
        r.fx = offset_coord(r.vx, ox);
        r.fy = offset_coord(r.vy, oy);
        r.tx = offset_coord(r.vx, m * ox);
        r.ty = offset_coord(r.vy, m * oy);
      end else if (pick < 90) begin
        r.fx    = near_coord(r.vx, span);
        r.fy    = near_coord(r.vy, span);
        r.tx    = near_coord(r.vx, span);
        r.ty    = near_coord(r.vy, span);
        r.reach = '0;
      end else begin
        // Vertex near an edge with a long distance, to hit saturation
        r.vx    = ($urandom_range(0, 1) == 1) ? near_coord(coord_t'(COORD_MAX - 4096), 4096)
                                               : near_coord(coord_t'(COORD_MIN + 4096), 4096);
        r.vy    = ($urandom_range(0, 1) == 1) ? near_coord(coord_t'(COORD_MAX - 4096), 4096)
                                               : near_coord(coord_t'(COORD_MIN + 4096), 4096);
        r.fx    = near_coord(r.vx, 65536);
        r.fy    = near_coord(r.vy, 65536);
        r.tx    = near_coord(r.vx, 65536);
        r.ty    = near_coord(r.vy, 65536);
        r.reach = ($urandom_range(0, 1) == 1) ? near_coord(coord_t'(COORD_MAX - 65536), 65536)
                                               : near_coord(coord_t'(COORD_MIN + 65536), 65536);
      end
      send_point(r);
    end

    // Drop valid, let every result come back, then allow for the pipeline depth
    req_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (LATENCY + 8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
